FILE: sv/aelex_pkg.sv
// Shared types and constants for the arithmetic expression lexer.
package aelex_pkg;

  localparam int unsigned CharW         = 8;
  localparam int unsigned TokValW       = 32;
  localparam int unsigned DefValueWidth = 32;

  // Token classes carried in token_type.
  typedef enum logic [2:0] {
    TOK_NUMBER  = 3'd0,
    TOK_ADD     = 3'd1,
    TOK_MUL     = 3'd2,
    TOK_MOD     = 3'd3,
    TOK_PAREN   = 3'd4,
    TOK_INVALID = 3'd5,
    TOK_END     = 3'd6
  } tok_type_e;

  // ASCII codes the lexer recognizes.
  localparam logic [CharW-1:0] ChPlus   = 8'h2B;
  localparam logic [CharW-1:0] ChMinus  = 8'h2D;
  localparam logic [CharW-1:0] ChSlash  = 8'h2F;
  localparam logic [CharW-1:0] ChStar   = 8'h2A;
  localparam logic [CharW-1:0] ChPct    = 8'h25;
  localparam logic [CharW-1:0] ChLParen = 8'h28;
  localparam logic [CharW-1:0] ChRParen = 8'h29;
  localparam logic [CharW-1:0] ChZero   = 8'h30;
  localparam logic [CharW-1:0] ChNine   = 8'h39;
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChTab    = 8'h09;
  localparam logic [CharW-1:0] ChLf     = 8'h0A;

  typedef struct packed {
    tok_type_e          ttype;
    logic [TokValW-1:0] value;
    logic               last_of_run;
    logic               input_end;
  } tok_t;

endpackage

FILE: sv/aelex_if.sv
// Handshake interfaces for the character and token channels of the lexer.
interface aelex_char_if;
  import aelex_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             final_char;

  modport source (output valid, char_code, final_char, input ready);
  modport sink   (input valid, char_code, final_char, output ready);
endinterface

interface aelex_tok_if;
  import aelex_pkg::*;

  logic               valid;
  logic               ready;
  tok_type_e          token_type;
  logic [TokValW-1:0] token_value;
  logic               last_of_run;
  logic               input_end;

  modport source (output valid, token_type, token_value, last_of_run, input_end, input ready);
  modport sink   (input valid, token_type, token_value, last_of_run, input_end, output ready);
endinterface

FILE: sv/arith_expression_lexer_core.sv
// A character waits in the input stage register, then its tokens go to the queue.
// Throughput: one character word per cycle while the queue has two slots free; a
//   character that yields two tokens puts them out singly on the single-token port.
// The token queue (4 entries) takes a new character only with two slots free.
// Reset (rst_ni low, asynchronous) clears the accumulator, the pending and error
//   flags, the input stage and the queue.
module arith_expression_lexer_core #(
  parameter int unsigned VALUE_WIDTH = aelex_pkg::DefValueWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  aelex_char_if.sink char_i,
  aelex_tok_if.source token_o
);
  import aelex_pkg::*;

  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);
  localparam int unsigned ProdW  = VALUE_WIDTH + 4;

  // Input stage: holds one character word until the queue can take its tokens.
  logic             s_valid_q, s_valid_d;
  logic [CharW-1:0] s_char_q;
  logic             s_fin_q;

  // Lexer state.
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic                   pend_q, pend_d;
  logic                   halt_q, halt_d;

  // Token queue.
  tok_t            q_mem [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] q_cnt_q, q_cnt_d;

  logic in_fire, adv, pop;

  // Classification of the staged character.
  logic       is_digit, is_ws, is_op;
  tok_type_e  op_type;
  logic [ProdW-1:0]       prod;
  logic                   sat;
  logic [VALUE_WIDTH-1:0] acc_new;

  logic has_a, has_op, has_b, has_end;
  logic [1:0] tok_cnt;
  tok_t tok0, tok1;

  // Advance the stage only with room for two tokens, so no token is ever lost.
  assign adv          = (q_cnt_q <= CntW'(QDepth - 2));
  assign char_i.ready = !s_valid_q || adv;
  assign in_fire      = char_i.valid && char_i.ready;
  assign pop          = token_o.valid && token_o.ready;

  always_comb begin
    s_valid_d = s_valid_q;
    if (in_fire) begin
      s_valid_d = 1'b1;
    end else if (adv) begin
      s_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= s_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s_char_q <= char_i.char_code;
      s_fin_q  <= char_i.final_char;
    end
  end

  // Classify the character: digits, whitespace, operators; the rest is invalid.
  always_comb begin
    is_digit = (s_char_q >= ChZero) && (s_char_q <= ChNine);
    is_ws    = (s_char_q == ChSpace) || (s_char_q == ChTab) || (s_char_q == ChLf);
    is_op    = 1'b1;
    op_type  = TOK_INVALID;
    unique case (s_char_q)
      ChPlus, ChMinus:    op_type = TOK_ADD;
      ChSlash, ChStar:    op_type = TOK_MUL;
      ChPct:              op_type = TOK_MOD;
      ChLParen, ChRParen: op_type = TOK_PAREN;
      default: begin
        op_type = TOK_INVALID;
        is_op   = 1'b0;
      end
    endcase
  end

  // Accumulate acc * 10 + digit; any carry above the value width saturates.
  assign prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
              + ProdW'(s_char_q[3:0]);
  assign sat     = |prod[ProdW-1:VALUE_WIDTH];
  assign acc_new = sat ? '1 : prod[VALUE_WIDTH-1:0];

  // Token sequence per character: flushed number, then operator or invalid,
  // else a number flushed by the last character, else an end token.
  always_comb begin
    has_a   = !halt_q && !is_digit && pend_q;
    has_op  = !halt_q && !is_digit && !is_ws;
    has_b   = s_fin_q && !halt_q && is_digit;
    has_end = s_fin_q && !has_a && !has_op && !has_b;
    tok_cnt = 2'(has_a) + 2'(has_op) + 2'(has_b) + 2'(has_end);

    tok1.ttype       = is_op ? op_type : TOK_INVALID;
    tok1.value       = TokValW'(s_char_q);
    tok1.last_of_run = 1'b1;
    tok1.input_end   = s_fin_q;

    tok0.last_of_run = (tok_cnt == 2'd1);
    tok0.input_end   = s_fin_q && (tok_cnt == 2'd1);
    if (has_a) begin
      tok0.ttype = TOK_NUMBER;
      tok0.value = TokValW'(acc_q);
    end else if (has_op) begin
      tok0.ttype = tok1.ttype;
      tok0.value = tok1.value;
    end else if (has_b) begin
      tok0.ttype = TOK_NUMBER;
      tok0.value = TokValW'(acc_new);
    end else begin
      tok0.ttype = TOK_END;
      tok0.value = '0;
    end
  end

  // Next lexer state; the last character returns everything to reset values.
  always_comb begin
    acc_d  = acc_q;
    pend_d = pend_q;
    halt_d = halt_q;
    if (s_valid_q && adv) begin
      if (!halt_q) begin
        if (is_digit) begin
          acc_d  = acc_new;
          pend_d = 1'b1;
        end else begin
          acc_d  = '0;
          pend_d = 1'b0;
          if (!is_op && !is_ws) begin
            halt_d = 1'b1;
          end
        end
      end
      if (s_fin_q) begin
        acc_d  = '0;
        pend_d = 1'b0;
        halt_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pend_q <= 1'b0;
      halt_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      pend_q <= pend_d;
      halt_q <= halt_d;
    end
  end

  // Queue bookkeeping: push up to two tokens, pop one.
  always_comb begin
    q_cnt_d = q_cnt_q;
    if (s_valid_q && adv) begin
      q_cnt_d = q_cnt_d + CntW'(tok_cnt);
    end
    if (pop) begin
      q_cnt_d = q_cnt_d - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      q_cnt_q <= q_cnt_d;
      if (s_valid_q && adv) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(tok_cnt);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_q && adv) begin
      q_mem[wr_ptr_q] <= tok0;
      if (tok_cnt == 2'd2) begin
        q_mem[wr_ptr_q + PtrW'(1)] <= tok1;
      end
    end
  end

  // Drive the head token word.
  assign token_o.valid       = (q_cnt_q != '0);
  assign token_o.token_type  = q_mem[rd_ptr_q].ttype;
  assign token_o.token_value = q_mem[rd_ptr_q].value;
  assign token_o.last_of_run = q_mem[rd_ptr_q].last_of_run;
  assign token_o.input_end   = q_mem[rd_ptr_q].input_end;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the arithmetic expression lexer core.
`timescale 1ns / 100ps

module tb_top;
  import aelex_pkg::*;

  localparam int unsigned ValueW        = DefValueWidth;
  localparam logic [63:0] ValueMax      = (64'd1 << ValueW) - 64'd1;
  localparam int          ClkHalf       = 6;
  localparam int          ResetCycles   = 5;
  localparam int          SettleCycles  = 8;
  localparam int          TimeoutCycles = 400_000;

  logic clk;
  logic rst_n;

  aelex_char_if char_if ();
  aelex_tok_if  tok_if ();

  arith_expression_lexer_core #(
    .VALUE_WIDTH(ValueW)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .char_i (char_if),
    .token_o(tok_if)
  );

  // Idle odds, in percent per cycle, for the character sender and the token sink.
  int send_idle_pct;
  int recv_stall_pct;

  // Tokens the lexer still owes, oldest first.
  tok_t expected_toks[$];
  int   mismatches;
  // Characters that the lexer acts on; ones dropped after an error are left out.
  int   lexed_chars;

  // Own copy of the lexer state.
  logic [63:0] lex_accum;
  logic        lex_pending;
  logic        lex_halted;

  string op_chars    = "+-*/%()";
  string space_chars = " \t\n";

  always #ClkHalf clk = ~clk;

  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    char_if.valid       = 1'b0;
    char_if.char_code   = '0;
    char_if.final_char  = 1'b0;
    tok_if.ready        = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    mismatches          = 0;
    lexed_chars         = 0;
    lex_accum           = '0;
    lex_pending         = 1'b0;
    lex_halted          = 1'b0;
  end

  // Token sink: drop ready at random according to the current stall odds.
  always @(posedge clk) begin
    tok_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic tok_t make_tok(tok_type_e kind, logic [63:0] val);
    tok_t t;
    t.ttype       = kind;
    t.value       = val[TokValW-1:0];
    t.last_of_run = 1'b0;
    t.input_end   = 1'b0;
    return t;
  endfunction

  // Advance the lexer copy by one character and queue the tokens it owes.
  task automatic lex_char(input logic [CharW-1:0] c, input logic fin);
    tok_t        toks[2];
    int          n;
    logic [63:0] digit;
    n = 0;
    if (!lex_halted || fin) lexed_chars++;
    if (!lex_halted) begin
      if (c >= ChZero && c <= ChNine) begin
        // Build the number, clamping at the largest value that fits.
        digit = 64'(c - ChZero);
        if (lex_accum > (ValueMax - digit) / 64'd10) lex_accum = ValueMax;
        else lex_accum = lex_accum * 64'd10 + digit;
        lex_pending = 1'b1;
      end else begin
        // Any non-digit closes a number in progress first.
        if (lex_pending) begin
          toks[n] = make_tok(TOK_NUMBER, lex_accum);
          n++;
          lex_pending = 1'b0;
          lex_accum   = '0;
        end
        if (c == ChPlus || c == ChMinus) begin
          toks[n] = make_tok(TOK_ADD, 64'(c));
          n++;
        end else if (c == ChSlash || c == ChStar) begin
          toks[n] = make_tok(TOK_MUL, 64'(c));
          n++;
        end else if (c == ChPct) begin
          toks[n] = make_tok(TOK_MOD, 64'(c));
          n++;
        end else if (c == ChLParen || c == ChRParen) begin
          toks[n] = make_tok(TOK_PAREN, 64'(c));
          n++;
        end else if (c == ChSpace || c == ChTab || c == ChLf) begin
          // whitespace only separates
        end else begin
          toks[n] = make_tok(TOK_INVALID, 64'(c));
          n++;
          lex_halted = 1'b1;
        end
      end
    end
    if (fin) begin
      // End of expression: flush the number; owe a bare end token if nothing else is owed.
      if (lex_pending) begin
        toks[n] = make_tok(TOK_NUMBER, lex_accum);
        n++;
      end
      if (n == 0) begin
        toks[n] = make_tok(TOK_END, '0);
        n++;
      end
      toks[n-1].input_end = 1'b1;
      lex_accum   = '0;
      lex_pending = 1'b0;
      lex_halted  = 1'b0;
    end
    if (n > 0) toks[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) expected_toks.push_back(toks[i]);
  endtask

  // Send one character word; returns at the edge that accepts it.
  // Valid stays high on return so back-to-back words need no extra step.
  task automatic send_char(input logic [CharW-1:0] c, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      char_if.valid <= 1'b0;
      @(posedge clk);
    end
    char_if.valid      <= 1'b1;
    char_if.char_code  <= c;
    char_if.final_char <= fin;
    do @(posedge clk); while (!char_if.ready);
    lex_char(c, fin);
  endtask

  task automatic send_text(input string s, input logic fin_last);
    for (int i = 0; i < s.len(); i++) send_char(s[i], fin_last && (i == s.len() - 1));
  endtask

  // Hold the sender off until every owed token has come out.
  task automatic wait_drained();
    char_if.valid <= 1'b0;
    while (expected_toks.size() != 0) @(posedge clk);
  endtask

  // One expression of random parts: numbers, operators, whitespace and the odd
  // stray byte that trips the error path. The last character carries the end mark.
  task automatic send_expression();
    logic [CharW-1:0] text[$];
    int               n_parts;
    int               len;
    int               pick;
    n_parts = $urandom_range(1, 8);
    for (int p = 0; p < n_parts; p++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        // Mostly short numbers, now and then long enough to clamp.
        len = ($urandom_range(15) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
        repeat (len) text.push_back(ChZero + CharW'($urandom_range(9)));
      end else if (pick < 80) begin
        text.push_back(op_chars[$urandom_range(op_chars.len() - 1)]);
      end else if (pick < 92) begin
        text.push_back(space_chars[$urandom_range(space_chars.len() - 1)]);
      end else begin
        text.push_back(CharW'($urandom_range(255)));
      end
    end
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic send_expressions(input int n_chars);
    int start;
    start = lexed_chars;
    while (lexed_chars - start < n_chars) send_expression();
  endtask

  // Checker: compare every accepted token word with the oldest one owed.
  always @(posedge clk) begin : token_check
    tok_t want;
    if (rst_n && tok_if.valid && tok_if.ready) begin
      if (expected_toks.size() == 0) begin
        $error("unexpected token: token_type %0d token_value %0d",
               tok_if.token_type, tok_if.token_value);
        mismatches++;
      end else begin
        want = expected_toks.pop_front();
        if (tok_if.token_type !== want.ttype) begin
          $error("token_type: expected %0d, got %0d", want.ttype, tok_if.token_type);
          mismatches++;
        end
        if (tok_if.token_value !== want.value) begin
          $error("token_value: expected %0d, got %0d", want.value, tok_if.token_value);
          mismatches++;
        end
        if (tok_if.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                 tok_if.last_of_run);
          mismatches++;
        end
        if (tok_if.input_end !== want.input_end) begin
          $error("input_end: expected %0b, got %0b", want.input_end, tok_if.input_end);
          mismatches++;
        end
      end
    end
  end

  // Every token class, whitespace ending numbers, clamping, stray bytes,
  // characters dropped after an error and the bare end token.
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_text("(9)%/*-\t5 8\n", 1'b1);
    send_char(ChZero + 8'd3, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("a", 1'b0);
    send_char(ChPlus, 1'b0);
    send_char(8'h00, 1'b1);
    send_text(" ", 1'b1);
    send_text("4294967296", 1'b1);
    send_char(8'h80, 1'b1);
    wait_drained();
  endtask

  task automatic test_stream_no_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_expressions(210);
    wait_drained();
  endtask

  task automatic test_sender_gaps();
    send_idle_pct  = 61;
    recv_stall_pct = 0;
    send_expressions(210);
    wait_drained();
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct  = 0;
    recv_stall_pct = 61;
    send_expressions(210);
    wait_drained();
  endtask

  task automatic test_both_idle();
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    send_expressions(210);
    wait_drained();
  endtask

  // Let the token queue run dry between expressions, then resume.
  task automatic test_pause_until_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 30;
    repeat (8) begin
      send_expression();
      wait_drained();
    end
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_stream_no_idle();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_pause_until_drained();
    // Let any stray token surface before judging.
    recv_stall_pct = 0;
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("** arith_expression_lexer_core: PASSED **");
    end else begin
      $display("** arith_expression_lexer_core: FAILED **");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    #(TimeoutCycles * 2 * ClkHalf);
    $display("** arith_expression_lexer_core: FAILED **");
    $finish;
  end

endmodule
